FILE: rtl/mea_pkg.sv
// shared types, mode codes and helpers for the 6502 effective address unit
package mea_pkg;

    localparam logic [3:0] MODE_ACC  = 4'd0;
    localparam logic [3:0] MODE_IMP  = 4'd1;
    localparam logic [3:0] MODE_IMM  = 4'd2;
    localparam logic [3:0] MODE_REL  = 4'd3;
    localparam logic [3:0] MODE_ZP   = 4'd4;
    localparam logic [3:0] MODE_ZPX  = 4'd5;
    localparam logic [3:0] MODE_ZPY  = 4'd6;
    localparam logic [3:0] MODE_ABS  = 4'd7;
    localparam logic [3:0] MODE_ABSX = 4'd8;
    localparam logic [3:0] MODE_ABSY = 4'd9;
    localparam logic [3:0] MODE_IND  = 4'd10;
    localparam logic [3:0] MODE_INDX = 4'd11;
    localparam logic [3:0] MODE_INDY = 4'd12;

    localparam logic [15:0] NO_ADDRESS = 16'hFFFF;
    localparam logic [15:0] PAGE_MASK  = 16'hFF00;
    localparam logic [15:0] BYTE_MASK  = 16'h00FF;

    typedef struct packed {
        logic        we;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } t_mem_req;

    function automatic logic [1:0] mode_len(input logic [3:0] mode);
        logic [1:0] len;
        case (mode)
            MODE_IMM, MODE_REL, MODE_ZP, MODE_ZPX, MODE_ZPY,
            MODE_INDX, MODE_INDY: len = 2'd1;
            MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_IND: len = 2'd2;
            default: len = 2'd0;
        endcase
        return len;
    endfunction

endpackage

FILE: rtl/mea_ram.sv
// single-port byte memory with registered read data
module mea_ram #(
    parameter int ADDR_BITS = 16
) (
    input  logic              i_clk,
    input  mea_pkg::t_mem_req i_req,
    output logic [7:0]        o_rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;
    logic [ADDR_BITS-1:0] index;

    assign index = i_req.addr[ADDR_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[index] <= i_req.wdata;
        end
        r_rdata <= r_mem[index];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mea_seq.sv
// fetch sequencer: walks operand and pointer reads and holds the result register
module mea_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_cmd,
    input  logic [15:0]       i_write_address,
    input  logic [7:0]        i_write_data,
    input  logic [3:0]        i_mode,
    input  logic [15:0]       i_pc_in,
    input  logic [7:0]        i_x_index,
    input  logic [7:0]        i_y_index,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [15:0]       o_effective_address,
    output logic [15:0]       o_next_pc,
    output logic              o_crossed_page,
    output logic              o_invalid_mode,
    output mea_pkg::t_mem_req o_req,
    input  logic [7:0]        i_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP0,
        S_OP1,
        S_PTR0,
        S_PTR1,
        S_DONE
    } t_state;

    t_state      r_state, n_state;
    logic [3:0]  r_mode;
    logic [15:0] r_pc;
    logic [7:0]  r_x, r_y;
    logic [7:0]  r_lo, n_lo;
    logic [15:0] r_next, n_next;
    logic [15:0] r_ea, r_npc;
    logic        r_cross, r_bad;
    logic        r_o_valid;
    logic [15:0] r_o_ea, r_o_npc;
    logic        r_o_cross, r_o_bad;

    logic        accept, out_free, fin;
    logic [15:0] f_ea, f_npc;
    logic        f_cross, f_bad;
    logic [15:0] rd_addr, base, sum;
    logic [7:0]  idx, zp, zp_next;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_o_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign idx      = (r_mode inside {mea_pkg::MODE_ABSX, mea_pkg::MODE_ZPX}) ? r_x : r_y;
    assign zp       = (r_mode == mea_pkg::MODE_INDX) ? (i_rdata + r_x) : i_rdata;
    assign zp_next  = zp + 8'd1;
    assign base     = {i_rdata, r_lo};
    assign sum      = base + {8'h00, idx};
    assign f_npc    = r_pc + {14'd0, mea_pkg::mode_len(r_mode)};

    always_comb begin
        case (r_state)
            S_IDLE: rd_addr = i_pc_in;
            S_OP0: begin
                if (r_mode == mea_pkg::MODE_INDX || r_mode == mea_pkg::MODE_INDY) begin
                    rd_addr = {8'h00, zp};
                end else begin
                    rd_addr = r_pc + 16'd1;
                end
            end
            S_OP1:  rd_addr = base;
            S_PTR0: rd_addr = r_next;
            default: rd_addr = r_pc;
        endcase
    end

    always_comb begin
        o_req.we    = accept && !i_cmd;
        o_req.addr  = o_req.we ? i_write_address : rd_addr;
        o_req.wdata = i_write_data;
    end

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_next  = r_next;
        fin     = 1'b0;
        f_ea    = mea_pkg::NO_ADDRESS;
        f_cross = 1'b0;
        f_bad   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept && i_cmd) begin
                    n_state = S_OP0;
                end
            end
            S_OP0: begin
                case (r_mode)
                    mea_pkg::MODE_ACC, mea_pkg::MODE_IMP: fin = 1'b1;
                    mea_pkg::MODE_IMM: begin
                        fin  = 1'b1;
                        f_ea = r_pc;
                    end
                    mea_pkg::MODE_REL: begin
                        fin  = 1'b1;
                        f_ea = {{8{i_rdata[7]}}, i_rdata};
                    end
                    mea_pkg::MODE_ZP: begin
                        fin  = 1'b1;
                        f_ea = {8'h00, i_rdata};
                    end
                    mea_pkg::MODE_ZPX, mea_pkg::MODE_ZPY: begin
                        fin  = 1'b1;
                        f_ea = {8'h00, i_rdata + idx};
                    end
                    mea_pkg::MODE_ABS, mea_pkg::MODE_ABSX, mea_pkg::MODE_ABSY,
                    mea_pkg::MODE_IND: begin
                        n_lo    = i_rdata;
                        n_state = S_OP1;
                    end
                    mea_pkg::MODE_INDX, mea_pkg::MODE_INDY: begin
                        n_next  = {8'h00, zp_next};
                        n_state = S_PTR0;
                    end
                    default: begin
                        fin   = 1'b1;
                        f_bad = 1'b1;
                    end
                endcase
            end
            S_OP1: begin
                case (r_mode)
                    mea_pkg::MODE_ABSX, mea_pkg::MODE_ABSY: begin
                        fin     = 1'b1;
                        f_ea    = sum;
                        f_cross = (sum[15:8] != i_rdata);
                    end
                    mea_pkg::MODE_IND: begin
                        // pointer high byte comes from the same page when the low byte is ff
                        if ((base & mea_pkg::BYTE_MASK) == mea_pkg::BYTE_MASK) begin
                            n_next = base & mea_pkg::PAGE_MASK;
                        end else begin
                            n_next = base + 16'd1;
                        end
                        n_state = S_PTR0;
                    end
                    default: begin
                        fin  = 1'b1;
                        f_ea = base;
                    end
                endcase
            end
            S_PTR0: begin
                n_lo    = i_rdata;
                n_state = S_PTR1;
            end
            S_PTR1: begin
                fin = 1'b1;
                if (r_mode == mea_pkg::MODE_INDY) begin
                    f_ea    = sum;
                    f_cross = (sum[15:8] != i_rdata);
                end else begin
                    f_ea = base;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (fin) begin
            n_state = out_free ? S_IDLE : S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_free) begin
                r_o_valid <= fin || (r_state == S_DONE);
            end
        end
        if (accept) begin
            r_mode <= i_mode;
            r_pc   <= i_pc_in;
            r_x    <= i_x_index;
            r_y    <= i_y_index;
        end
        r_lo   <= n_lo;
        r_next <= n_next;
        if (fin) begin
            r_ea    <= f_ea;
            r_npc   <= f_npc;
            r_cross <= f_cross;
            r_bad   <= f_bad;
        end
        if (out_free && fin) begin
            r_o_ea    <= f_ea;
            r_o_npc   <= f_npc;
            r_o_cross <= f_cross;
            r_o_bad   <= f_bad;
        end else if (out_free && r_state == S_DONE) begin
            r_o_ea    <= r_ea;
            r_o_npc   <= r_npc;
            r_o_cross <= r_cross;
            r_o_bad   <= r_bad;
        end
    end

    assign o_valid             = r_o_valid;
    assign o_effective_address = r_o_ea;
    assign o_next_pc           = r_o_npc;
    assign o_crossed_page      = r_o_cross;
    assign o_invalid_mode      = r_o_bad;

endmodule

FILE: rtl/mos6502_effective_address_unit.sv
// 6502 effective address unit top level: sequencer and byte memory
// a write request gives no result
// a resolve result is registered from S_OP0 for implied, immediate, relative and zero
// page modes, from S_OP1 for absolute modes, and from S_PTR1 after S_PTR0 for (zp,x),
// (zp),y and, after S_OP1, indirect; the next request is taken the cycle after the
// result is registered or a stalled result leaves, stalling input over the memory reads
// reset clears the control state only; memory contents stay undefined until written
module mos6502_effective_address_unit #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [15:0] i_write_address,
    input  logic [7:0]  i_write_data,
    input  logic [3:0]  i_mode,
    input  logic [15:0] i_pc_in,
    input  logic [7:0]  i_x_index,
    input  logic [7:0]  i_y_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_effective_address,
    output logic [15:0] o_next_pc,
    output logic        o_crossed_page,
    output logic        o_invalid_mode
);

    mea_pkg::t_mem_req mem_req;
    logic [7:0]        mem_rdata;

    mea_seq u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_cmd               (i_cmd),
        .i_write_address     (i_write_address),
        .i_write_data        (i_write_data),
        .i_mode              (i_mode),
        .i_pc_in             (i_pc_in),
        .i_x_index           (i_x_index),
        .i_y_index           (i_y_index),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_effective_address (o_effective_address),
        .o_next_pc           (o_next_pc),
        .o_crossed_page      (o_crossed_page),
        .o_invalid_mode      (o_invalid_mode),
        .o_req               (mem_req),
        .i_rdata             (mem_rdata)
    );

    mea_ram #(
        .ADDR_BITS (MEM_ADDR_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    a_write_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> (i_valid && !o_stall && !i_cmd))
        else $error("memory write without an accepted write request");

    a_resolve_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_cmd) |=> o_stall)
        else $error("resolve request did not hold off the next request");

    a_invalid_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid_mode) |->
            (o_effective_address == mea_pkg::NO_ADDRESS && !o_crossed_page))
        else $error("invalid mode result carries an address or page cross");

endmodule
